### rtl/bcd_signed_fixed_point_alu_unit_macros.svh
// Assertion macros for the BCD fixed-point ALU.
// Included by the top level; depends on nothing else.
`ifndef BCD_SIGNED_FIXED_POINT_ALU_UNIT_MACROS_SVH
`define BCD_SIGNED_FIXED_POINT_ALU_UNIT_MACROS_SVH

// Same-cycle implication
`define BSFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BSFA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bsfa_pkg.sv
// Shared constants, types and BCD helper functions for the decimal ALU.
// Used by every module of the block; depends on nothing.
package bsfa_pkg;

   localparam int DIGITS      = 16;
   localparam int FRAC_DIGITS = 10;
   localparam int IN_W        = 64;
   localparam int DW          = 4 * DIGITS;
   localparam int PROD_DIGITS = 2 * DIGITS;
   localparam int PW          = 4 * PROD_DIGITS;
   localparam int TREE_LVLS   = $clog2(DIGITS);
   localparam int PP_N        = 1 << TREE_LVLS;
   localparam int NODES       = 2 * PP_N - 1;
   localparam int NSTG        = 4 + TREE_LVLS;
   localparam int REQ_BITS    = 2 + 2 * IN_W + 2;
   localparam int REQ_W       = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = IN_W + 4;
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8;

   // request field offsets
   localparam int REQ_A_LO  = 2;
   localparam int REQ_AN    = 2 + IN_W;
   localparam int REQ_B_LO  = 3 + IN_W;
   localparam int REQ_BN    = 3 + 2 * IN_W;
   // result field offsets
   localparam int RSP_NEG   = IN_W;
   localparam int RSP_ORD   = IN_W + 1;
   localparam int RSP_OVF   = IN_W + 3;

   localparam logic [PW-1:0] BCD_SIX = {PROD_DIGITS{4'h6}};

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_CMP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ORD_LESS    = 2'd0,
      ORD_EQUAL   = 2'd1,
      ORD_GREATER = 2'd2
   } order_type;

   typedef struct packed {
      cmd_type         cmd;
      order_type       order;
      logic            mul_neg;
      logic            add_neg;
      logic [DW-1:0]   x;
      logic [DW-1:0]   y;
      logic            cin;
      logic            is_sub;
      logic [DW-1:0]   da;
      logic [DW-1:0]   db;
   } dec_type;

   typedef struct packed {
      cmd_type         cmd;
      order_type       order;
      logic            mul_neg;
      logic            add_neg;
      logic [DW-1:0]   sum_mag;
      logic            sum_ovf;
   } side_type;

   // Clamp non-decimal nibbles to 9, drop nibbles above DIGITS
   function automatic logic [DW-1:0] sanitize(input logic [IN_W-1:0] v);
      logic [DW-1:0] r;
      logic [3:0]    n;
      for (int i = 0; i < DIGITS; i++) begin
         n = v[4*i +: 4];
         r[4*i +: 4] = (n > 4'd9) ? 4'd9 : n;
      end
      return r;
   endfunction

   // Nine's complement of each digit
   function automatic logic [DW-1:0] nines(input logic [DW-1:0] v);
      logic [DW-1:0] r;
      for (int i = 0; i < DIGITS; i++) begin
         r[4*i +: 4] = 4'd9 - v[4*i +: 4];
      end
      return r;
   endfunction

   // Digit times digit as two BCD digits {tens, units}
   function automatic logic [7:0] digit_mul(input logic [3:0] a, input logic [3:0] b);
      logic [7:0]  p;
      logic [15:0] t;
      logic [7:0]  tens;
      logic [7:0]  units;
      p     = {4'd0, a} * {4'd0, b};
      t     = {8'd0, p} * 16'd205;
      tens  = {4'd0, t[14:11]};
      units = p - tens * 8'd10;
      return {tens[3:0], units[3:0]};
   endfunction

   // Packed BCD add over PROD_DIGITS digits: pre-bias by 6, binary add, un-bias
   function automatic logic [PW-1:0] bcd_add(input logic [PW-1:0] x, input logic [PW-1:0] y,
                                             input logic cin);
      logic [PW-1:0] u;
      logic [PW:0]   s;
      logic [PW-1:0] r;
      logic          c;
      u = x + BCD_SIX;
      s = {1'b0, u} + {1'b0, y} + {{PW{1'b0}}, cin};
      for (int i = 0; i < PROD_DIGITS; i++) begin
         if (i == PROD_DIGITS - 1) c = s[PW];
         else                      c = s[4*i+4] ^ u[4*i+4] ^ y[4*i+4];
         r[4*i +: 4] = c ? s[4*i +: 4] : (s[4*i +: 4] - 4'd6);
      end
      return r;
   endfunction

   // One partial product row: units plus tens shifted up a digit
   function automatic logic [PW-1:0] pp_row(input logic [DW-1:0] units,
                                            input logic [DW-1:0] tens);
      logic [PW-1:0] ue;
      logic [PW-1:0] te;
      ue = '0;
      te = '0;
      ue[DW-1:0] = units;
      te[DW+3:4] = tens;
      return bcd_add(ue, te, 1'b0);
   endfunction

endpackage

### rtl/bsfa_decode.sv
// First pipeline stage: operand cleanup, signed compare, add/subtract setup.
// Depends on bsfa_pkg.
module bsfa_decode (
   input  logic                   clock,
   input  logic                   en,
   input  logic [1:0]             command,
   input  logic [63:0]            a_digits,
   input  logic                   a_negative,
   input  logic [63:0]            b_digits,
   input  logic                   b_negative,
   output bsfa_pkg::dec_type      dec_ff
);

   bsfa_pkg::dec_type dec_in;

   always_comb begin
      logic [bsfa_pkg::DW-1:0] da;
      logic [bsfa_pkg::DW-1:0] db;
      logic sa, sb, eb, gt, eq, b_nz;
      da   = bsfa_pkg::sanitize(a_digits);
      db   = bsfa_pkg::sanitize(b_digits);
      b_nz = |db;
      // zero magnitude counts as positive
      sa   = a_negative & (|da);
      sb   = b_negative & b_nz;
      gt   = da > db;
      eq   = da == db;

      dec_in.cmd     = bsfa_pkg::cmd_type'(command);
      dec_in.da      = da;
      dec_in.db      = db;
      dec_in.mul_neg = sa ^ sb;

      // signed order of a against b
      priority if (sa != sb) begin
         dec_in.order = sa ? bsfa_pkg::ORD_LESS : bsfa_pkg::ORD_GREATER;
      end else if (eq) begin
         dec_in.order = bsfa_pkg::ORD_EQUAL;
      end else begin
         dec_in.order = (gt != sa) ? bsfa_pkg::ORD_GREATER : bsfa_pkg::ORD_LESS;
      end

      // effective sign of b, then larger minus smaller via ten's complement
      eb = (dec_in.cmd == bsfa_pkg::CMD_SUB) ? (!sb && b_nz) : sb;
      priority if (sa == eb) begin
         dec_in.x = da; dec_in.y = db; dec_in.cin = 1'b0;
         dec_in.is_sub = 1'b0; dec_in.add_neg = sa;
      end else if (gt || eq) begin
         dec_in.x = da; dec_in.y = bsfa_pkg::nines(db); dec_in.cin = 1'b1;
         dec_in.is_sub = 1'b1; dec_in.add_neg = sa;
      end else begin
         dec_in.x = db; dec_in.y = bsfa_pkg::nines(da); dec_in.cin = 1'b1;
         dec_in.is_sub = 1'b1; dec_in.add_neg = eb;
      end
   end

   always_ff @(posedge clock) begin
      if (en) dec_ff <= dec_in;
   end

endmodule

### rtl/bsfa_mult.sv
// BCD multiplier pipeline: digit products, partial rows, registered adder tree.
// Depends on bsfa_pkg; occupies stages 2 through NSTG-1.
module bsfa_mult (
   input  logic                        clock,
   input  logic [bsfa_pkg::NSTG:1]     en,
   input  logic [bsfa_pkg::DW-1:0]     da,
   input  logic [bsfa_pkg::DW-1:0]     db,
   output logic [bsfa_pkg::PW-1:0]     prod
);

   logic [bsfa_pkg::DW-1:0] units_in [bsfa_pkg::DIGITS];
   logic [bsfa_pkg::DW-1:0] tens_in  [bsfa_pkg::DIGITS];
   logic [bsfa_pkg::DW-1:0] units_ff [bsfa_pkg::DIGITS];
   logic [bsfa_pkg::DW-1:0] tens_ff  [bsfa_pkg::DIGITS];
   logic [bsfa_pkg::PW-1:0] tree_ff  [bsfa_pkg::NODES];

   // stage 2: every digit pair split into tens and units
   always_comb begin
      logic [7:0] dm;
      for (int j = 0; j < bsfa_pkg::DIGITS; j++) begin
         for (int i = 0; i < bsfa_pkg::DIGITS; i++) begin
            dm = bsfa_pkg::digit_mul(da[4*i +: 4], db[4*j +: 4]);
            units_in[j][4*i +: 4] = dm[3:0];
            tens_in[j][4*i +: 4]  = dm[7:4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int j = 0; j < bsfa_pkg::DIGITS; j++) begin
            units_ff[j] <= units_in[j];
            tens_ff[j]  <= tens_in[j];
         end
      end
   end

   // stage 3 leaves, then one tree level per stage; node n has children 2n+1, 2n+2
   for (genvar n = 0; n < bsfa_pkg::NODES; n++) begin : g_node
      if (n >= bsfa_pkg::PP_N - 1) begin : g_leaf
         localparam int J = n - (bsfa_pkg::PP_N - 1);
         if (J < bsfa_pkg::DIGITS) begin : g_row
            always_ff @(posedge clock) begin
               if (en[3]) tree_ff[n] <= bsfa_pkg::pp_row(units_ff[J], tens_ff[J]) << (4 * J);
            end
         end else begin : g_pad
            always_ff @(posedge clock) begin
               if (en[3]) tree_ff[n] <= '0;
            end
         end
      end else begin : g_sum
         localparam int DEPTH = $clog2(n + 2) - 1;
         localparam int STG   = 3 + bsfa_pkg::TREE_LVLS - DEPTH;
         always_ff @(posedge clock) begin
            if (en[STG]) tree_ff[n] <= bsfa_pkg::bcd_add(tree_ff[2*n+1], tree_ff[2*n+2], 1'b0);
         end
      end
   end

   assign prod = tree_ff[0];

endmodule

### rtl/bsfa_pack.sv
// Last stage: selects the result by command, scales the product, flags, packs.
// Depends on bsfa_pkg.
module bsfa_pack (
   input  logic                          clock,
   input  logic                          en,
   input  bsfa_pkg::side_type            side,
   input  logic [bsfa_pkg::PW-1:0]       prod,
   output logic [bsfa_pkg::RSP_W-1:0]    rsp_data_ff
);

   logic [bsfa_pkg::RSP_W-1:0] rsp_data_in;

   always_comb begin
      logic [bsfa_pkg::DW-1:0] mag;
      logic                    ovf;
      logic                    neg;
      unique case (side.cmd)
         bsfa_pkg::CMD_ADD, bsfa_pkg::CMD_SUB: begin
            mag = side.sum_mag;
            ovf = side.sum_ovf;
            neg = side.add_neg;
         end
         bsfa_pkg::CMD_MUL: begin
            // truncate fraction, anything above DIGITS integer range overflows
            mag = prod[4*bsfa_pkg::FRAC_DIGITS +: bsfa_pkg::DW];
            ovf = |prod[bsfa_pkg::PW-1 : 4*(bsfa_pkg::FRAC_DIGITS + bsfa_pkg::DIGITS)];
            neg = side.mul_neg;
         end
         default: begin
            mag = '0;
            ovf = 1'b0;
            neg = 1'b0;
         end
      endcase
      // zero is always positive
      neg = neg & (|mag);

      rsp_data_in = '0;
      rsp_data_in[bsfa_pkg::DW-1:0]                = mag;
      rsp_data_in[bsfa_pkg::RSP_NEG]               = neg;
      rsp_data_in[bsfa_pkg::RSP_ORD +: 2]          = side.order;
      rsp_data_in[bsfa_pkg::RSP_OVF]               = ovf;
   end

   always_ff @(posedge clock) begin
      if (en) rsp_data_ff <= rsp_data_in;
   end

endmodule

### rtl/bcd_signed_fixed_point_alu_unit.sv
// Signed BCD fixed-point ALU: add, subtract, multiply, compare.
// Stages, request to response: decode, digit products, partial-row leaves, adder tree levels, pack.
// Throughput: one item per cycle; every stage holds its own valid bit and
// stalls only when the stage after it is full.
// The multiplier's registered BCD adder tree sets the depth.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
`include "bcd_signed_fixed_point_alu_unit_macros.svh"

module bcd_signed_fixed_point_alu_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // command[1:0], a_digits[65:2], a_negative[66], b_digits[130:67], b_negative[131]
   input  logic [bsfa_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // result_digits[63:0], result_negative[64], order[66:65], overflow[67]
   output logic [bsfa_pkg::RSP_W-1:0]    rsp_tdata
);

   logic [bsfa_pkg::NSTG:1] valid_ff;
   logic [bsfa_pkg::NSTG:1] valid_in;
   logic [bsfa_pkg::NSTG:1] stage_en;
   bsfa_pkg::dec_type       dec;
   bsfa_pkg::side_type      side_ff [2:bsfa_pkg::NSTG-1];
   bsfa_pkg::side_type      side_in;
   logic [bsfa_pkg::PW-1:0] prod;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      stage_en[bsfa_pkg::NSTG] = !valid_ff[bsfa_pkg::NSTG] || rsp_tready;
      for (int k = bsfa_pkg::NSTG - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      for (int k = 1; k <= bsfa_pkg::NSTG; k++) begin
         if (stage_en[k]) valid_in[k] = (k == 1) ? req_tvalid : valid_ff[k-1];
         else             valid_in[k] = valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   assign req_tready = stage_en[1];
   assign rsp_tvalid = valid_ff[bsfa_pkg::NSTG];

   // stage 1
   bsfa_decode u_decode (
      .clock      (clock),
      .en         (stage_en[1]),
      .command    (req_tdata[1:0]),
      .a_digits   (req_tdata[bsfa_pkg::REQ_A_LO +: bsfa_pkg::IN_W]),
      .a_negative (req_tdata[bsfa_pkg::REQ_AN]),
      .b_digits   (req_tdata[bsfa_pkg::REQ_B_LO +: bsfa_pkg::IN_W]),
      .b_negative (req_tdata[bsfa_pkg::REQ_BN]),
      .dec_ff     (dec)
   );

   // stage 2: add/subtract in one BCD add, then carried alongside the multiplier
   always_comb begin
      logic [bsfa_pkg::PW-1:0] xe;
      logic [bsfa_pkg::PW-1:0] ye;
      logic [bsfa_pkg::PW-1:0] sum;
      xe = '0;
      ye = '0;
      xe[bsfa_pkg::DW-1:0] = dec.x;
      ye[bsfa_pkg::DW-1:0] = dec.y;
      sum = bsfa_pkg::bcd_add(xe, ye, dec.cin);
      side_in.cmd     = dec.cmd;
      side_in.order   = dec.order;
      side_in.mul_neg = dec.mul_neg;
      side_in.add_neg = dec.add_neg;
      side_in.sum_mag = sum[bsfa_pkg::DW-1:0];
      // a ten's complement carry out is not an overflow
      side_in.sum_ovf = !dec.is_sub && (|sum[bsfa_pkg::PW-1:bsfa_pkg::DW]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) side_ff[2] <= side_in;
   end

   for (genvar k = 3; k <= bsfa_pkg::NSTG - 1; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (stage_en[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   bsfa_mult u_mult (
      .clock (clock),
      .en    (stage_en),
      .da    (dec.da),
      .db    (dec.db),
      .prod  (prod)
   );

   bsfa_pack u_pack (
      .clock       (clock),
      .en          (stage_en[bsfa_pkg::NSTG]),
      .side        (side_ff[bsfa_pkg::NSTG-1]),
      .prod        (prod),
      .rsp_data_ff (rsp_tdata)
   );

   // checks
   `BSFA_ASSERT_IMP(a_zero_pos, clock, reset, (rsp_tvalid && rsp_tdata[bsfa_pkg::RSP_NEG]), (|rsp_tdata[bsfa_pkg::IN_W-1:0]), "negative zero result")
   `BSFA_ASSERT_IMP(a_order_code, clock, reset, rsp_tvalid, (rsp_tdata[bsfa_pkg::RSP_ORD +: 2] != 2'd3), "invalid order code")
   `BSFA_ASSERT_IMP(a_empty_ready, clock, reset, (!valid_ff[1]), req_tready, "empty first stage not ready")
   `BSFA_ASSERT_NXT(a_held_item, clock, reset, (rsp_tvalid && !rsp_tready), valid_ff[bsfa_pkg::NSTG], "stalled item lost")

endmodule
